### rtl/core/wbps_pkg.sv
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types, register indexes and helpers for the wildcard byte
// pattern scanner.
// ----------------------------------------------------------------------------
package wbps_pkg;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD0 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD1 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD2 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD3 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_BASE_ADDR = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_ONLY = 3'd6;

  // Pattern storage: four 64-bit words, 32 bytes in all
  localparam int PATTERN_BYTES = 32;
  localparam int PATTERN_BITS  = 8 * PATTERN_BYTES;
  localparam int LENGTH_W      = 6;
  // Wide enough for any clamped length up to the largest pattern bound (64)
  localparam int CLAMP_W       = 7;
  localparam int ADDRESS_W     = 64;

  typedef struct packed {
    logic [7:0] image_byte;
    logic       last_byte;
  } wbps_in_t;

  typedef struct packed {
    logic                 match_valid;
    logic [ADDRESS_W-1:0] match_address;
    logic                 scan_done;
  } wbps_out_t;

  // Limit the configured length to the window depth.
  function automatic logic [CLAMP_W-1:0] clamp_length(
    input logic [LENGTH_W-1:0] len,
    input logic [CLAMP_W-1:0]  max_len
  );
    logic [CLAMP_W-1:0] len_ext;
    len_ext = CLAMP_W'(len);
    return (len_ext > max_len) ? max_len : len_ext;
  endfunction

  // Pattern byte at a position; positions past the stored bytes read as zero.
  function automatic logic [7:0] pat_byte(
    input logic [PATTERN_BITS-1:0] bits,
    input logic [CLAMP_W-1:0]      idx
  );
    logic [7:0] b;
    if (idx >= CLAMP_W'(PATTERN_BYTES)) begin
      b = 8'h00;
    end else begin
      b = bits[{idx[4:0], 3'b000} +: 8];
    end
    return b;
  endfunction

endpackage

### rtl/core/wbps_align.sv
// ----------------------------------------------------------------------------
// wbps_align
// Registers the pattern re-ordered to line up with the byte window
// (window slot j against pattern byte len-1-j), with a care bit per slot.
// ----------------------------------------------------------------------------
module wbps_align #(
  parameter int MAX_PATTERN = 32
) (
  input  logic                              clk,
  input  logic [wbps_pkg::PATTERN_BITS-1:0] pattern_bits,
  input  logic [wbps_pkg::LENGTH_W-1:0]     pattern_length,
  output logic [7:0]                        aln_byte [MAX_PATTERN],
  output logic [MAX_PATTERN-1:0]            aln_care
);

  logic [7:0]             aln_byte_next [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] aln_care_next;

  always_comb begin
    logic [wbps_pkg::CLAMP_W-1:0] lc;
    logic [wbps_pkg::CLAMP_W-1:0] idx;
    lc = wbps_pkg::clamp_length(pattern_length, wbps_pkg::CLAMP_W'(MAX_PATTERN));
    for (int j = 0; j < MAX_PATTERN; j++) begin
      idx = '0;
      if (wbps_pkg::CLAMP_W'(j) < lc) begin
        idx = lc - wbps_pkg::CLAMP_W'(j) - wbps_pkg::CLAMP_W'(1);
        aln_byte_next[j] = wbps_pkg::pat_byte(pattern_bits, idx);
        // first pattern byte is exact; zero elsewhere is a wildcard
        aln_care_next[j] = (idx == '0) || (aln_byte_next[j] != 8'h00);
      end else begin
        aln_byte_next[j] = 8'h00;
        aln_care_next[j] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    aln_byte <= aln_byte_next;
    aln_care <= aln_care_next;
  end

endmodule

### rtl/core/wildcard_byte_pattern_scan.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scan
// Streams image bytes through a window and reports the start address of
// every window that matches a configured wildcard byte pattern.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                           | Direction | Moves
//  --------+-----------------------------------+-----------+-------------------
//  in      | in_valid, in_ready, in_data       | into block| one image byte
//  out     | out_valid, out_ready, out_data    | out       | match / done report
//  cfg     | cfg_write, cfg_index, cfg_data    | into block| register write
//
//  One byte request per cycle is accepted while no held result stalls the
//  pipe. The accepting edge writes the byte into the window; when stage 1
//  advances, the masked window compare and the address add are registered as the offered result.
//  Reset (rst, synchronous) empties the pipe and clears fill, position and
//  first-match tracking; no clearing pass is needed.
//  A held result stalls the compare stage; the input side keeps taking a
//  request as long as the compare stage is empty or moving.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scan #(
  parameter int MAX_PATTERN   = 32,
  parameter int POSITION_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  // byte requests
  input  logic                             in_valid,
  output logic                             in_ready,
  input  wbps_pkg::wbps_in_t               in_data,
  // results
  output logic                             out_valid,
  input  logic                             out_ready,
  output wbps_pkg::wbps_out_t              out_data,
  // configuration writes
  input  logic                             cfg_write,
  input  logic [wbps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int FILL_W = $clog2(MAX_PATTERN + 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [wbps_pkg::PATTERN_BITS-1:0] pattern_bits;
  logic [wbps_pkg::LENGTH_W-1:0]     pattern_length;
  logic [wbps_pkg::ADDRESS_W-1:0]    base_addr;
  logic                              first_only;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bits   <= '0;
      pattern_length <= '0;
      base_addr      <= '0;
      first_only     <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        wbps_pkg::REG_PATTERN_WORD0:  pattern_bits[63:0]    <= cfg_data;
        wbps_pkg::REG_PATTERN_WORD1:  pattern_bits[127:64]  <= cfg_data;
        wbps_pkg::REG_PATTERN_WORD2:  pattern_bits[191:128] <= cfg_data;
        wbps_pkg::REG_PATTERN_WORD3:  pattern_bits[255:192] <= cfg_data;
        wbps_pkg::REG_PATTERN_LENGTH: pattern_length <= cfg_data[wbps_pkg::LENGTH_W-1:0];
        wbps_pkg::REG_BASE_ADDR:      base_addr      <= cfg_data;
        wbps_pkg::REG_FIRST_ONLY:     first_only     <= cfg_data[0];
        default: ; // drop writes to unknown indexes
      endcase
    end
  end

  // Pattern lined up with the window, refreshed every cycle. A write lands
  // here through the align register, in time for the compare of any byte taken after it.
  logic [7:0]             aln_byte [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] aln_care;

  wbps_align #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_align (
    .clk            (clk),
    .pattern_bits   (pattern_bits),
    .pattern_length (pattern_length),
    .aln_byte       (aln_byte),
    .aln_care       (aln_care)
  );

  // --------------------------------------------------------------------------
  // Handshake control
  // --------------------------------------------------------------------------
  logic s1_valid;
  logic s1_adv;
  logic in_accept;

  assign s1_adv    = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_adv;
  assign in_accept = in_valid && in_ready;

  // --------------------------------------------------------------------------
  // Stage 1: window shift, fill and position tracking
  // --------------------------------------------------------------------------
  logic [7:0]                   window [MAX_PATTERN];
  logic [FILL_W-1:0]            fill;
  logic [FILL_W-1:0]            fill_next;
  logic [POSITION_BITS-1:0]     position;
  logic [wbps_pkg::CLAMP_W-1:0] lc;
  logic                         s1_last;
  logic                         s1_fill_ok;
  logic [POSITION_BITS-1:0]     s1_start;

  assign lc = wbps_pkg::clamp_length(pattern_length, wbps_pkg::CLAMP_W'(MAX_PATTERN));
  assign fill_next = (fill == FILL_W'(MAX_PATTERN)) ? fill : fill + FILL_W'(1);

  // Window bytes beyond the fill count are never compared, so the window
  // itself needs no reset or clearing at the end of an image.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      window[0] <= in_data.image_byte;
      for (int k = 1; k < MAX_PATTERN; k++) begin
        window[k] <= window[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      position <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        // restart fill and position after the last byte of an image
        fill     <= in_data.last_byte ? '0 : fill_next;
        position <= in_data.last_byte ? '0 : position + POSITION_BITS'(1);
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_last    <= in_data.last_byte;
      s1_fill_ok <= (lc != '0) && (wbps_pkg::CLAMP_W'(fill_next) >= lc);
      // match start offset: position - (len - 1), wrapping
      s1_start   <= position - POSITION_BITS'(lc) + POSITION_BITS'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: masked compare, first-match filter, result register
  // --------------------------------------------------------------------------
  logic [MAX_PATTERN-1:0]         slot_ok;
  logic                           hit;
  logic                           first_found;
  logic [wbps_pkg::ADDRESS_W-1:0] match_addr;

  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      slot_ok[j] = !aln_care[j] || (window[j] == aln_byte[j]);
    end
  end

  assign hit        = s1_fill_ok && (&slot_ok) && !(first_only && first_found);
  assign match_addr = base_addr + wbps_pkg::ADDRESS_W'(s1_start);

  always_ff @(posedge clk) begin
    if (rst) begin
      first_found <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (s1_adv) begin
        // hold first-match state for the rest of the image only
        if (s1_last) begin
          first_found <= 1'b0;
        end else if (hit && first_only) begin
          first_found <= 1'b1;
        end
        out_valid <= hit || s1_last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data.match_valid   <= hit;
      out_data.match_address <= hit ? match_addr : '0;
      out_data.scan_done     <= s1_last;
    end
  end

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the wildcard byte pattern scanner. Image bytes go
// in as valid/ready requests; an in-bench scoreboard model of the window
// compare predicts every match and end-of-scan report, and each report that
// leaves the block is checked in order against it. Directed cases come
// first, then randomized images under several sender/receiver idle mixes.
// ----------------------------------------------------------------------------
module testbench;

  localparam int          CLK_PERIOD      = 20;
  localparam int          RESET_CYCLES    = 12;
  localparam int          SCAN_DEPTH      = 32;   // window depth of the instance
  localparam int          DRAIN_CYCLES    = 8;    // pipe is stage 1 plus the result register
  localparam int          HOLD_OFF_CYCLES = 200;
  localparam int          MAX_REPORTS     = 10;
  localparam int unsigned LIMIT_CYCLES    = 1_000_000;
  localparam int          PHASE_ITEMS     = 450;
  // Index with no register behind it; writes to it must be dropped.
  localparam logic [wbps_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  typedef logic [7:0] byte_q_t[$];

  logic                             clk;
  logic                             rst       = 1'b1;
  logic                             in_valid  = 1'b0;
  logic                             in_ready;
  wbps_pkg::wbps_in_t               in_data   = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  wbps_pkg::wbps_out_t              out_data;
  logic                             cfg_write = 1'b0;
  logic [wbps_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [wbps_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

  // Idle mix for the current phase, in percent per cycle.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_off_requests = 0;

  int unsigned failures = 0;

  // Scoreboard copy of the register file.
  logic [63:0] cfg_pattern [4];
  logic [5:0]  cfg_length;
  logic [63:0] cfg_base;
  logic        cfg_only_first;

  // Scoreboard copy of the scan state; scan_window[0] is the newest byte.
  logic [7:0]  scan_window [SCAN_DEPTH];
  int unsigned scan_fill;
  logic [31:0] scan_offset;
  logic        first_reported;

  wbps_pkg::wbps_out_t expected_reports[$];

  // Stimulus generator's view of the current pattern (clamped length).
  logic [7:0]  gen_bytes [SCAN_DEPTH];
  int unsigned gen_len;

  wildcard_byte_pattern_scan u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("testbench: errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Scoreboard model
  // --------------------------------------------------------------------------

  function automatic void clear_scan();
    for (int i = 0; i < SCAN_DEPTH; i++) scan_window[i] = 8'h00;
    scan_fill      = 0;
    scan_offset    = '0;
    first_reported = 1'b0;
  endfunction

  function automatic void clear_registers();
    for (int i = 0; i < 4; i++) cfg_pattern[i] = '0;
    cfg_length     = '0;
    cfg_base       = '0;
    cfg_only_first = 1'b0;
  endfunction

  function automatic void update_register(input logic [wbps_pkg::CFG_INDEX_W-1:0] idx,
                                          input logic [63:0] value);
    case (idx)
      wbps_pkg::REG_PATTERN_WORD0:  cfg_pattern[0] = value;
      wbps_pkg::REG_PATTERN_WORD1:  cfg_pattern[1] = value;
      wbps_pkg::REG_PATTERN_WORD2:  cfg_pattern[2] = value;
      wbps_pkg::REG_PATTERN_WORD3:  cfg_pattern[3] = value;
      wbps_pkg::REG_PATTERN_LENGTH: cfg_length     = value[5:0];
      wbps_pkg::REG_BASE_ADDR:      cfg_base       = value;
      wbps_pkg::REG_FIRST_ONLY:     cfg_only_first = value[0];
      default: ;  // unmapped index: drop the write
    endcase
  endfunction

  // Pattern byte i; everything past the stored 32 bytes is a wildcard.
  function automatic logic [7:0] sig_byte(input int unsigned i);
    if (i >= 32) return 8'h00;
    return cfg_pattern[i / 8][8 * (i % 8) +: 8];
  endfunction

  // Shift one byte into the window and queue the report it produces, if any.
  function automatic void predict_scan(input logic [7:0] value, input logic last);
    int unsigned         span;
    bit                  hit;
    logic [7:0]          p;
    logic [31:0]         start;
    wbps_pkg::wbps_out_t rep;
    span = (cfg_length > SCAN_DEPTH) ? SCAN_DEPTH : cfg_length;
    hit  = 1'b0;
    for (int i = SCAN_DEPTH - 1; i > 0; i--) scan_window[i] = scan_window[i - 1];
    scan_window[0] = value;
    if (scan_fill < SCAN_DEPTH) scan_fill++;

    // Lead byte is exact; zero elsewhere matches anything.
    if (span != 0 && scan_fill >= span && scan_window[span - 1] == sig_byte(0)) begin
      hit = 1'b1;
      for (int i = 1; i < span; i++) begin
        p = sig_byte(i);
        if (p != 8'h00 && p != scan_window[span - 1 - i]) hit = 1'b0;
      end
    end
    if (hit && cfg_only_first && first_reported) hit = 1'b0;

    rep = '0;
    if (hit) begin
      start             = scan_offset - 32'(span - 1);
      rep.match_valid   = 1'b1;
      rep.match_address = cfg_base + {32'h0, start};
      if (cfg_only_first) first_reported = 1'b1;
    end
    rep.scan_done = last;

    if (last) clear_scan();
    else scan_offset = scan_offset + 32'd1;

    if (hit || last) expected_reports = {expected_reports, rep};
  endfunction

  function automatic void note_failure(input string what);
    if (failures < MAX_REPORTS) $display("mismatch: %s", what);
    failures++;
  endfunction

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------

  // Drive out_ready per the phase's stall rate; on request, hold it low for a
  // long stretch so the pipe backs up into the input side.
  initial begin : result_sink
    int unsigned held;
    int unsigned served;
    served = 0;
    forever begin
      @(posedge clk);
      if (served != hold_off_requests) begin
        served = hold_off_requests;
        out_ready <= 1'b0;
        held = 0;
        while (held < HOLD_OFF_CYCLES) begin
          @(posedge clk);
          held++;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare every accepted report with the oldest prediction.
  always @(posedge clk) begin
    wbps_pkg::wbps_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        note_failure($sformatf("unexpected report valid=%0b addr=%h done=%0b",
                               out_data.match_valid, out_data.match_address,
                               out_data.scan_done));
      end else begin
        want = expected_reports.pop_front();
        if (out_data.match_valid !== want.match_valid)
          note_failure($sformatf("match_valid expected %0b got %0b",
                                 want.match_valid, out_data.match_valid));
        if (out_data.match_address !== want.match_address)
          note_failure($sformatf("match_address expected %h got %h",
                                 want.match_address, out_data.match_address));
        if (out_data.scan_done !== want.scan_done)
          note_failure($sformatf("scan_done expected %0b got %0b",
                                 want.scan_done, out_data.scan_done));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Offer one byte request and hold it until taken. Valid stays high on return
  // so back-to-back requests need no re-raise; an idle gap drops it first.
  task automatic send_byte(input logic [7:0] value, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{image_byte: value, last_byte: last};
    do @(posedge clk); while (!in_ready);
    predict_scan(value, last);
  endtask

  task automatic send_image(input byte_q_t img, input bit terminate);
    foreach (img[i]) send_byte(img[i], terminate && (i == img.size() - 1));
  endtask

  // Drop valid, wait for every predicted report, then let the pipe empty of
  // bytes that produce no report before touching registers.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write; the block must be idle.
  task automatic write_reg(input logic [wbps_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [63:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    update_register(idx, value);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // Registers at reset give an empty pattern: only the end-of-scan report.
  task automatic test_reset_state();
    byte_q_t img;
    img = '{8'h00, 8'hFF};
    send_image(img, 1'b1);
    settle();
  endtask

  // A zero lead byte is not a wildcard; a match may end on the last byte.
  task automatic test_exact_lead_byte();
    byte_q_t img;
    write_reg(wbps_pkg::REG_PATTERN_WORD0, 64'h0000_0000_0000_AB00);
    write_reg(wbps_pkg::REG_PATTERN_LENGTH, 64'd2);
    write_reg(wbps_pkg::REG_BASE_ADDR, 64'h0000_0000_0000_1000);
    img = '{8'h00, 8'hAB, 8'h05, 8'hAB, 8'h00, 8'hAB};
    send_image(img, 1'b1);
    settle();
  endtask

  // Zero bytes inside the pattern skip any image byte.
  task automatic test_wildcard_gaps();
    byte_q_t img;
    write_reg(wbps_pkg::REG_PATTERN_WORD0, 64'h0000_0000_4200_0041);
    write_reg(wbps_pkg::REG_PATTERN_LENGTH, 64'd4);
    write_reg(wbps_pkg::REG_BASE_ADDR, 64'h8000_0000_0000_0000);
    img = '{8'h41, 8'h07, 8'h08, 8'h42, 8'h41, 8'hFF, 8'h00, 8'h42};
    send_image(img, 1'b1);
    settle();
  endtask

  // Base plus offset wraps at 64 bits; the length write keeps its low bits only.
  task automatic test_address_wrap();
    byte_q_t img;
    write_reg(wbps_pkg::REG_PATTERN_WORD0, 64'h0000_0000_0000_00FF);
    write_reg(wbps_pkg::REG_PATTERN_WORD1, '1);
    write_reg(wbps_pkg::REG_PATTERN_WORD2, '1);
    write_reg(wbps_pkg::REG_PATTERN_WORD3, '1);
    write_reg(wbps_pkg::REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFC1);
    write_reg(wbps_pkg::REG_BASE_ADDR, '1);
    img = '{8'hFF, 8'hFF};
    send_image(img, 1'b1);
    settle();
  endtask

  // Only-first mode reports once per image and re-arms after the last byte.
  task automatic test_first_match_only();
    byte_q_t img;
    write_reg(wbps_pkg::REG_PATTERN_WORD0, 64'h0000_0000_0000_005A);
    write_reg(wbps_pkg::REG_PATTERN_LENGTH, 64'd1);
    write_reg(wbps_pkg::REG_BASE_ADDR, 64'h0);
    write_reg(wbps_pkg::REG_FIRST_ONLY, 64'hFFFF_FFFF_FFFF_FFFF);
    img = '{8'h5A, 8'h5A, 8'h5A};
    send_image(img, 1'b1);
    img = '{8'h5A};
    send_image(img, 1'b1);
    settle();
    write_reg(wbps_pkg::REG_FIRST_ONLY, 64'h0);
  endtask

  // A write to the unmapped index must leave every register alone.
  task automatic test_unused_register();
    byte_q_t img;
    write_reg(REG_UNUSED, '1);
    img = '{8'h5A};
    send_image(img, 1'b1);
    settle();
  endtask

  // Hold off the result side while bytes that all match keep coming, so
  // the pipe fills and in_ready must fall until the hold ends.
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(wbps_pkg::REG_PATTERN_WORD0, 64'h0000_0000_0000_0077);
    write_reg(wbps_pkg::REG_PATTERN_LENGTH, 64'd1);
    write_reg(wbps_pkg::REG_BASE_ADDR, 64'h0000_0000_0001_0000);
    hold_off_requests++;
    for (int i = 0; i < 40; i++) send_byte(8'h77, i == 39);
    settle();
  endtask

  // --------------------------------------------------------------------------
  // Random traffic
  // --------------------------------------------------------------------------

  // Pick a fresh pattern, length, base and mode, and write all registers.
  task automatic randomize_setup();
    int unsigned r;
    logic [5:0]  len_code;
    logic [63:0] word;
    r = $urandom_range(99);
    if (r < 5)       len_code = 6'd0;
    else if (r < 15) len_code = 6'($urandom_range(63, 33));   // clamps to the depth
    else if (r < 23) len_code = 6'd32;
    else if (r < 40) len_code = 6'($urandom_range(31, 9));
    else             len_code = 6'($urandom_range(8, 1));
    gen_len = (len_code > SCAN_DEPTH) ? SCAN_DEPTH : len_code;

    // Small alphabet keeps chance matches frequent; zero lead bytes stay exact.
    gen_bytes[0] = ($urandom_range(1) == 0) ? 8'($urandom_range(3)) : 8'($urandom);
    for (int i = 1; i < SCAN_DEPTH; i++) begin
      r = $urandom_range(99);
      if (r < 30)      gen_bytes[i] = 8'h00;
      else if (r < 60) gen_bytes[i] = 8'($urandom_range(3));
      else             gen_bytes[i] = 8'($urandom);
    end

    for (int w = 0; w < 4; w++) begin
      for (int j = 0; j < 8; j++) word[8 * j +: 8] = gen_bytes[8 * w + j];
      // pattern words take indexes 0..3
      write_reg(wbps_pkg::REG_PATTERN_WORD0 + wbps_pkg::CFG_INDEX_W'(w), word);
    end
    word = {$urandom, $urandom};
    word[5:0] = len_code;
    write_reg(wbps_pkg::REG_PATTERN_LENGTH, word);
    r = $urandom_range(99);
    if (r < 15)      word = '0;
    else if (r < 30) word = '1;
    else             word = {$urandom, $urandom};
    write_reg(wbps_pkg::REG_BASE_ADDR, word);
    word = {$urandom, $urandom};
    write_reg(wbps_pkg::REG_FIRST_ONLY, word);
    if ($urandom_range(9) == 0) write_reg(REG_UNUSED, {$urandom, $urandom});
  endtask

  // Build an image from whole pattern copies, broken prefixes and filler.
  task automatic send_random_image(output int unsigned count);
    byte_q_t     img;
    int unsigned target;
    int unsigned r;
    int unsigned cut;
    target = ($urandom_range(99) < 85) ? $urandom_range(gen_len + 6, 1)
                                       : $urandom_range(70, 1);
    while (img.size() < target) begin
      r = $urandom_range(99);
      if (gen_len != 0 && r < 30) begin
        for (int k = 0; k < gen_len; k++)
          img = {img, (k != 0 && gen_bytes[k] == 8'h00) ? 8'($urandom) : gen_bytes[k]};
      end else if (gen_len > 1 && r < 40) begin
        cut = $urandom_range(gen_len - 1, 1);
        for (int k = 0; k < cut; k++)
          img = {img, (k != 0 && gen_bytes[k] == 8'h00) ? 8'($urandom) : gen_bytes[k]};
        img = {img, ~gen_bytes[cut]};
      end else if (r < 70) begin
        img = {img, 8'($urandom_range(3))};
      end else begin
        img = {img, 8'($urandom)};
      end
    end
    count = img.size();
    // Now and then leave the image open so state carries into the next one.
    send_image(img, $urandom_range(9) != 0);
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    int unsigned sent;
    int unsigned n;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      settle();
      randomize_setup();
      repeat ($urandom_range(4, 1)) begin
        send_random_image(n);
        sent += n;
      end
    end
    settle();
  endtask

  task automatic test_random_traffic();
    run_phase(0, 0);     // back to back both ways
    run_phase(80, 0);    // sparse requests
    run_phase(0, 80);    // slow result side
    run_phase(8, 8);     // light jitter on both
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    clear_registers();
    clear_scan();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_exact_lead_byte();
    test_wildcard_gaps();
    test_address_wrap();
    test_first_match_only();
    test_unused_register();
    test_output_backpressure();
    test_random_traffic();

    recv_stall_pct = 0;
    settle();
    if (expected_reports.size() != 0)
      note_failure($sformatf("%0d reports never arrived", expected_reports.size()));
    if (failures == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
